// File: rtl/cdo_pkg.sv
// Shared types, constants and calendar tables for the date day-offset block.
`default_nettype none

package cdo_pkg;

    // Field widths
    localparam int DAY_W      = 5;
    localparam int MON_W      = 4;
    localparam int YEAR_W     = 14;
    localparam int OPY_W      = YEAR_W + 1;   // year operand, reaches max_year + 1
    localparam int OFF_W      = 23;
    localparam int DBY_W      = 23;           // days from year 0 up to 16384
    localparam int ABS_W      = DBY_W + 2;    // signed absolute day count
    localparam int DN_W       = 22;
    localparam int REM_W      = 9;            // day within a year
    localparam int CUM_W      = 9;
    localparam int ST_W       = 2;
    localparam int TDATA_W    = 48;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = YEAR_W;

    // Register reset values
    localparam logic [YEAR_W-1:0] MIN_YEAR_RST = YEAR_W'(1900);
    localparam logic [YEAR_W-1:0] MAX_YEAR_RST = YEAR_W'(9999);

    // Day-before-year arithmetic: floor(x / 100) == (x * RECIP_100) >> RECIP_100_SH
    localparam int DAYS_PER_YEAR = 365;
    localparam int CENTURY       = 100;
    localparam int RECIP_100     = 5243;
    localparam int RECIP_100_SH  = 19;

    // Configuration register indexes
    typedef logic [CFG_ADDR_W-1:0] t_cfg_addr;
    localparam t_cfg_addr CFG_MIN_YEAR = 1'b0;
    localparam t_cfg_addr CFG_MAX_YEAR = 1'b1;

    // Result status codes
    typedef enum logic [ST_W-1:0] {
        ST_OK       = 2'd0,
        ST_BAD_DATE = 2'd1,
        ST_RANGE    = 2'd2
    } t_status;

    // Year operand select for the day-before-year unit
    typedef enum logic [2:0] {
        OP_MIN_YEAR,
        OP_IN_YEAR,
        OP_LIM_YEAR,
        OP_MID_YEAR,
        OP_LO_YEAR
    } t_op_sel;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_BASE,
        S_IN_YEAR,
        S_DAY_NUM,
        S_TOTAL,
        S_RANGE,
        S_BS_EVAL,
        S_BS_CMP,
        S_RES_YEAR,
        S_REM,
        S_MONTH,
        S_DONE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        t_op_sel op_sel;
        logic    in_ld;
        logic    base_ld;
        logic    dn_ld;
        logic    tot_ld;
        logic    bs_init;
        logic    bs_step;
        logic    rem_ld;
        logic    mon_ld;
        logic    out_ld;
        t_status kind;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic date_ok;
        logic in_range;
        logic init_more;
        logic step_more;
        logic out_free;
    } t_sts;

    // Month lengths and days before each month, indexed by month code
    localparam logic [DAY_W-1:0] MONTH_LEN [16] = '{
        5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
        5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
    };
    localparam logic [CUM_W-1:0] CUM_DAYS [16] = '{
        9'd0, 9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd0, 9'd0, 9'd0
    };

    function automatic logic [DAY_W-1:0] days_in_month(input logic [MON_W-1:0] m,
                                                       input logic lp);
        logic [DAY_W-1:0] len;
        len = MONTH_LEN[m];
        if (m == MON_W'(2) && lp) begin
            len = DAY_W'(29);
        end
        return len;
    endfunction

    function automatic logic [CUM_W-1:0] days_before_month(input logic [MON_W-1:0] m,
                                                           input logic lp);
        logic [CUM_W-1:0] cum;
        cum = CUM_DAYS[m];
        if (lp && m > MON_W'(2) && m <= MON_W'(12)) begin
            cum = cum + CUM_W'(1);
        end
        return cum;
    endfunction

endpackage

`default_nettype wire

// File: rtl/cdo_dby.sv
// Registered unit: days in all years before a given year, and its leap flag.
`default_nettype none

module cdo_dby (
    input  wire logic                          i_clk,
    input  wire logic [cdo_pkg::OPY_W-1:0]     i_year,
    output logic      [cdo_pkg::DBY_W-1:0]     o_dby,
    output logic                               o_leap
);

    localparam int PROD_W = cdo_pkg::OPY_W + 13;
    localparam int C100_W = PROD_W - cdo_pkg::RECIP_100_SH;
    localparam int LEAP_W = 13;

    logic [cdo_pkg::OPY_W-1:0]  y_up100;
    logic [PROD_W-1:0]          prod100;
    logic [C100_W-1:0]          c100;
    logic [C100_W:0]            c100_up4;
    logic [cdo_pkg::OPY_W-1:0]  y_up4;
    logic [LEAP_W-1:0]          leaps;
    logic [cdo_pkg::DBY_W:0]    y365;
    logic [cdo_pkg::OPY_W:0]    c100_x100;
    logic                       div100;
    logic [cdo_pkg::DBY_W-1:0]  n_dby;
    logic                       n_leap;

    // Count leap years with ceilings: ceil(y/4) - ceil(y/100) + ceil(ceil(y/100)/4)
    always_comb begin
        y_up100   = i_year + cdo_pkg::OPY_W'(99);
        prod100   = PROD_W'(y_up100) * PROD_W'(cdo_pkg::RECIP_100);
        c100      = prod100[PROD_W-1:cdo_pkg::RECIP_100_SH];
        c100_up4  = {1'b0, c100} + (C100_W+1)'(3);
        y_up4     = i_year + cdo_pkg::OPY_W'(3);
        leaps     = LEAP_W'(y_up4[cdo_pkg::OPY_W-1:2]) - LEAP_W'(c100)
                  + LEAP_W'(c100_up4[C100_W:2]);
        y365      = (cdo_pkg::DBY_W+1)'(i_year) * (cdo_pkg::DBY_W+1)'(cdo_pkg::DAYS_PER_YEAR);
        n_dby     = cdo_pkg::DBY_W'(y365 + (cdo_pkg::DBY_W+1)'(leaps));
        // Century years are leap only when the century count is a multiple of four
        c100_x100 = (cdo_pkg::OPY_W+1)'(c100) * (cdo_pkg::OPY_W+1)'(cdo_pkg::CENTURY);
        div100    = (c100_x100 == {1'b0, i_year});
        n_leap    = (i_year[1:0] == 2'b00 && !div100) || (div100 && c100[1:0] == 2'b00);
    end

    // Register the result
    always_ff @(posedge i_clk) begin
        o_dby  <= n_dby;
        o_leap <= n_leap;
    end

endmodule

`default_nettype wire

// File: rtl/cdo_ctrl.sv
// Controller state machine that sequences one date request through the datapath.
`default_nettype none

module cdo_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    input  wire cdo_pkg::t_sts i_sts,
    output cdo_pkg::t_cmd      o_cmd
);

    cdo_pkg::t_state  r_state, n_state;
    cdo_pkg::t_status r_kind, n_kind;

    // Hold state and result kind
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cdo_pkg::S_IDLE;
            r_kind  <= cdo_pkg::ST_OK;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        unique case (r_state)
            cdo_pkg::S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = cdo_pkg::S_BASE;
                end
            end
            cdo_pkg::S_BASE:    n_state = cdo_pkg::S_IN_YEAR;
            cdo_pkg::S_IN_YEAR: n_state = cdo_pkg::S_DAY_NUM;
            cdo_pkg::S_DAY_NUM: begin
                if (i_sts.date_ok) begin
                    n_state = cdo_pkg::S_TOTAL;
                end else begin
                    n_kind  = cdo_pkg::ST_BAD_DATE;
                    n_state = cdo_pkg::S_DONE;
                end
            end
            cdo_pkg::S_TOTAL:   n_state = cdo_pkg::S_RANGE;
            cdo_pkg::S_RANGE: begin
                if (!i_sts.in_range) begin
                    n_kind  = cdo_pkg::ST_RANGE;
                    n_state = cdo_pkg::S_DONE;
                end else if (i_sts.init_more) begin
                    n_state = cdo_pkg::S_BS_EVAL;
                end else begin
                    n_state = cdo_pkg::S_RES_YEAR;
                end
            end
            cdo_pkg::S_BS_EVAL: n_state = cdo_pkg::S_BS_CMP;
            cdo_pkg::S_BS_CMP: begin
                n_state = i_sts.step_more ? cdo_pkg::S_BS_EVAL : cdo_pkg::S_RES_YEAR;
            end
            cdo_pkg::S_RES_YEAR: n_state = cdo_pkg::S_REM;
            cdo_pkg::S_REM:      n_state = cdo_pkg::S_MONTH;
            cdo_pkg::S_MONTH: begin
                n_kind  = cdo_pkg::ST_OK;
                n_state = cdo_pkg::S_DONE;
            end
            cdo_pkg::S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = cdo_pkg::S_IDLE;
                end
            end
            default: n_state = cdo_pkg::S_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_s_tready = 1'b0;
        o_cmd      = '0;
        o_cmd.kind = r_kind;
        unique case (r_state)
            cdo_pkg::S_IDLE: begin
                o_s_tready  = 1'b1;
                o_cmd.in_ld = i_s_tvalid;
            end
            cdo_pkg::S_BASE: o_cmd.op_sel = cdo_pkg::OP_MIN_YEAR;
            cdo_pkg::S_IN_YEAR: begin
                o_cmd.op_sel  = cdo_pkg::OP_IN_YEAR;
                o_cmd.base_ld = 1'b1;
            end
            cdo_pkg::S_DAY_NUM: begin
                o_cmd.op_sel = cdo_pkg::OP_LIM_YEAR;
                o_cmd.dn_ld  = 1'b1;
            end
            cdo_pkg::S_TOTAL:    o_cmd.tot_ld = 1'b1;
            cdo_pkg::S_RANGE:    o_cmd.bs_init = i_sts.in_range;
            cdo_pkg::S_BS_EVAL:  o_cmd.op_sel = cdo_pkg::OP_MID_YEAR;
            cdo_pkg::S_BS_CMP:   o_cmd.bs_step = 1'b1;
            cdo_pkg::S_RES_YEAR: o_cmd.op_sel = cdo_pkg::OP_LO_YEAR;
            cdo_pkg::S_REM:      o_cmd.rem_ld = 1'b1;
            cdo_pkg::S_MONTH:    o_cmd.mon_ld = 1'b1;
            cdo_pkg::S_DONE:     o_cmd.out_ld = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/cdo_dpath.sv
// Datapath: config registers, date operands, year search, month split, output register.
`default_nettype none

module cdo_dpath (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [cdo_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  wire logic [cdo_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  wire logic [cdo_pkg::TDATA_W-1:0]       i_s_tdata,
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    output logic      [cdo_pkg::TDATA_W-1:0]       o_m_tdata,
    output logic      [cdo_pkg::ST_W-1:0]          o_m_tuser,
    input  wire cdo_pkg::t_cmd                     i_cmd,
    output cdo_pkg::t_sts                          o_sts
);

    localparam int DAY_LSB  = 0;
    localparam int MON_LSB  = DAY_LSB + cdo_pkg::DAY_W;
    localparam int YEAR_LSB = MON_LSB + cdo_pkg::MON_W;
    localparam int OFF_LSB  = YEAR_LSB + cdo_pkg::YEAR_W;
    localparam int DN_LSB   = YEAR_LSB + cdo_pkg::YEAR_W;
    localparam int OUT_USED = DN_LSB + cdo_pkg::DN_W;
    localparam int Y_W      = cdo_pkg::YEAR_W;

    // Midpoint of a search window, rounded up
    function automatic logic [Y_W-1:0] mid_of(input logic [Y_W-1:0] lo,
                                              input logic [Y_W-1:0] hi);
        logic [Y_W:0] span;
        span = {1'b0, hi} - {1'b0, lo} + (Y_W+1)'(1);
        return lo + span[Y_W:1];
    endfunction

    logic [Y_W-1:0]                  r_min_year, r_max_year;
    logic [cdo_pkg::DAY_W-1:0]       r_in_day;
    logic [cdo_pkg::MON_W-1:0]       r_in_month;
    logic [Y_W-1:0]                  r_in_year;
    logic [cdo_pkg::OFF_W-1:0]       r_in_off;
    logic [cdo_pkg::DBY_W-1:0]       r_base, r_dn_abs, r_lim;
    logic signed [cdo_pkg::ABS_W-1:0] r_abs;
    logic [Y_W-1:0]                  r_lo, r_hi, r_mid;
    logic [cdo_pkg::REM_W-1:0]       r_rem;
    logic                            r_rleap;
    logic [cdo_pkg::MON_W-1:0]       r_res_month;
    logic                            r_out_valid;
    logic [cdo_pkg::TDATA_W-1:0]     r_out_tdata;
    logic [cdo_pkg::ST_W-1:0]        r_out_tuser;

    logic [cdo_pkg::OPY_W-1:0]       op_year;
    logic [cdo_pkg::DBY_W-1:0]       dby;
    logic                            dby_leap;
    logic                            go_up;
    logic [Y_W-1:0]                  n_lo, n_hi;
    logic [cdo_pkg::DBY_W-1:0]       n_dn_abs;
    logic signed [cdo_pkg::ABS_W-1:0] n_abs;
    logic [cdo_pkg::DBY_W-1:0]       abs_low;
    logic [cdo_pkg::DBY_W-1:0]       rem_full;
    logic [12:1]                     month_hit;
    logic [cdo_pkg::DAY_W-1:0]       res_day;
    logic [cdo_pkg::DBY_W-1:0]       dn_ok, dn_range;
    logic [cdo_pkg::TDATA_W-1:0]     n_out_tdata;
    logic [cdo_pkg::ST_W-1:0]        n_out_tuser;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_year <= cdo_pkg::MIN_YEAR_RST;
            r_max_year <= cdo_pkg::MAX_YEAR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                cdo_pkg::CFG_MIN_YEAR: r_min_year <= i_cfg_wdata;
                cdo_pkg::CFG_MAX_YEAR: r_max_year <= i_cfg_wdata;
            endcase
        end
    end

    // Select the year operand for the day-before-year unit
    always_comb begin
        case (i_cmd.op_sel)
            cdo_pkg::OP_MIN_YEAR: op_year = {1'b0, r_min_year};
            cdo_pkg::OP_IN_YEAR:  op_year = {1'b0, r_in_year};
            cdo_pkg::OP_LIM_YEAR: op_year = {1'b0, r_max_year} + cdo_pkg::OPY_W'(1);
            cdo_pkg::OP_MID_YEAR: op_year = {1'b0, r_mid};
            cdo_pkg::OP_LO_YEAR:  op_year = {1'b0, r_lo};
            default:              op_year = '0;
        endcase
    end

    cdo_dby u_dby (
        .i_clk  (i_clk),
        .i_year (op_year),
        .o_dby  (dby),
        .o_leap (dby_leap)
    );

    // Day number, shifted total and search step
    always_comb begin
        n_dn_abs = dby + cdo_pkg::DBY_W'(cdo_pkg::days_before_month(r_in_month, dby_leap))
                 + cdo_pkg::DBY_W'(r_in_day) - cdo_pkg::DBY_W'(1);
        n_abs    = $signed({2'b00, r_dn_abs})
                 + $signed({{(cdo_pkg::ABS_W-cdo_pkg::OFF_W){r_in_off[cdo_pkg::OFF_W-1]}},
                            r_in_off});
        abs_low  = r_abs[cdo_pkg::DBY_W-1:0];
        go_up    = (dby <= abs_low);
        n_lo     = go_up ? r_mid : r_lo;
        n_hi     = go_up ? r_hi : r_mid - Y_W'(1);
        rem_full = abs_low - dby;
    end

    // Status to the controller
    always_comb begin
        o_sts.date_ok   = (r_in_year >= r_min_year) && (r_in_year <= r_max_year)
                       && (r_in_month >= cdo_pkg::MON_W'(1))
                       && (r_in_month <= cdo_pkg::MON_W'(12))
                       && (r_in_day >= cdo_pkg::DAY_W'(1))
                       && (r_in_day <= cdo_pkg::days_in_month(r_in_month, dby_leap));
        o_sts.in_range  = (r_abs >= $signed({2'b00, r_base}))
                       && (r_abs < $signed({2'b00, r_lim}));
        o_sts.init_more = (r_min_year < r_max_year);
        o_sts.step_more = (n_lo < n_hi);
        o_sts.out_free  = !r_out_valid || i_m_tready;
    end

    // Month from the day within the year
    always_comb begin
        for (int k = 1; k <= 12; k++) begin
            month_hit[k] = (r_rem >= cdo_pkg::days_before_month(cdo_pkg::MON_W'(k), r_rleap));
        end
    end

    // Capture the request and advance the work registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.in_ld) begin
            r_in_day   <= i_s_tdata[DAY_LSB +: cdo_pkg::DAY_W];
            r_in_month <= i_s_tdata[MON_LSB +: cdo_pkg::MON_W];
            r_in_year  <= i_s_tdata[YEAR_LSB +: Y_W];
            r_in_off   <= i_s_tdata[OFF_LSB +: cdo_pkg::OFF_W];
        end
        if (i_cmd.base_ld) begin
            r_base <= dby;
        end
        if (i_cmd.dn_ld) begin
            r_dn_abs <= n_dn_abs;
        end
        if (i_cmd.tot_ld) begin
            r_abs <= n_abs;
            r_lim <= dby;
        end
        if (i_cmd.bs_init) begin
            r_lo  <= r_min_year;
            r_hi  <= r_max_year;
            r_mid <= mid_of(r_min_year, r_max_year);
        end else if (i_cmd.bs_step) begin
            r_lo  <= n_lo;
            r_hi  <= n_hi;
            r_mid <= mid_of(n_lo, n_hi);
        end
        if (i_cmd.rem_ld) begin
            r_rem   <= rem_full[cdo_pkg::REM_W-1:0];
            r_rleap <= dby_leap;
        end
        if (i_cmd.mon_ld) begin
            r_res_month <= cdo_pkg::MON_W'($countones(month_hit));
        end
    end

    // Assemble the result
    always_comb begin
        res_day  = cdo_pkg::DAY_W'(r_rem
                 - cdo_pkg::days_before_month(r_res_month, r_rleap) + cdo_pkg::REM_W'(1));
        dn_ok    = abs_low - r_base;
        dn_range = r_dn_abs - r_base;
        n_out_tdata = '0;
        n_out_tdata[DAY_LSB +: cdo_pkg::DAY_W]  = r_in_day;
        n_out_tdata[MON_LSB +: cdo_pkg::MON_W]  = r_in_month;
        n_out_tdata[YEAR_LSB +: Y_W]            = r_in_year;
        n_out_tuser = cdo_pkg::ST_W'(i_cmd.kind);
        case (i_cmd.kind)
            cdo_pkg::ST_OK: begin
                n_out_tdata[DAY_LSB +: cdo_pkg::DAY_W] = res_day;
                n_out_tdata[MON_LSB +: cdo_pkg::MON_W] = r_res_month;
                n_out_tdata[YEAR_LSB +: Y_W]           = r_lo;
                n_out_tdata[DN_LSB +: cdo_pkg::DN_W]   = dn_ok[cdo_pkg::DN_W-1:0];
            end
            cdo_pkg::ST_RANGE: begin
                n_out_tdata[DN_LSB +: cdo_pkg::DN_W]   = dn_range[cdo_pkg::DN_W-1:0];
            end
            default: begin
                n_out_tuser = cdo_pkg::ST_W'(cdo_pkg::ST_BAD_DATE);
            end
        endcase
        n_out_tdata[cdo_pkg::TDATA_W-1:OUT_USED] = '0;
    end

    // Output register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_ld) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            r_out_tdata <= n_out_tdata;
            r_out_tuser <= n_out_tuser;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_tdata;
    assign o_m_tuser  = r_out_tuser;

endmodule

`default_nettype wire

// File: rtl/calendar_date_day_offset_top.sv
// Top level of the Gregorian date day-offset block.
//
// Usage:
//   Slave stream takes one request per transfer: a date (day, month, year)
//   and a signed day offset. Master stream returns one result per request:
//   the shifted date and its day number from 1 January of min_year, or for a
//   rejected request the input date; a status in tuser (ok, invalid input
//   date, result outside the window). The config port writes min_year (index
//   0) and max_year (index 1); write it only while no request is in flight.
// Timing:
//   An invalid date goes from the date check straight to the result. A valid
//   date runs k binary-search steps over the year window, where k is
//   ceil(log2(max_year - min_year + 1)), at most 14. The year search shares one
//   registered day-before-year unit, and each step passes through an evaluate
//   and a compare state. One request is worked on at a time, and a new one is
//   taken in the cycle after the result is loaded into the output register.
// Reset and stall:
//   Synchronous reset empties the output register, returns the controller to
//   idle and restores min_year 1900, max_year 9999. A stalled result holds in
//   the output register while the next request is accepted and worked on.
`default_nettype none

module calendar_date_day_offset_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Config write port
    input  wire logic                              i_cfg_we,
    input  wire logic [cdo_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  wire logic [cdo_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    // Request stream
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    // tdata: in_day[4:0], in_month[8:5], in_year[22:9], day_offset[45:23], zero[47:46]
    input  wire logic [cdo_pkg::TDATA_W-1:0]       i_s_tdata,
    // Result stream
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    // tdata: out_day[4:0], out_month[8:5], out_year[22:9], day_number[44:23], zero[47:45]
    output logic      [cdo_pkg::TDATA_W-1:0]       o_m_tdata,
    // tuser: status[1:0]
    output logic      [cdo_pkg::ST_W-1:0]          o_m_tuser
);

    cdo_pkg::t_cmd cmd;
    cdo_pkg::t_sts sts;

    cdo_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    cdo_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

`default_nettype wire

// File: rtl/cdo_checker.sv
// Port-level checker for the date day-offset block, bound to the top level.
`default_nettype none

module cdo_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_cfg_we,
    input wire logic [cdo_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input wire logic [cdo_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input wire logic                              i_s_tvalid,
    input wire logic                              o_s_tready,
    input wire logic [cdo_pkg::TDATA_W-1:0]       i_s_tdata,
    input wire logic                              o_m_tvalid,
    input wire logic                              i_m_tready,
    input wire logic [cdo_pkg::TDATA_W-1:0]       o_m_tdata,
    input wire logic [cdo_pkg::ST_W-1:0]          o_m_tuser
);

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // Stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled result changed");

    // One request at a time: no request accepted in the cycle after one
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("request taken while busy");

    // A good result has a nonzero day and a month from 1 to 12
    a_ok_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == cdo_pkg::ST_W'(cdo_pkg::ST_OK) |->
            o_m_tdata[4:0] != 5'd0 && o_m_tdata[8:5] != 4'd0 && o_m_tdata[8:5] <= 4'd12)
        else $error("ok result with impossible date");

    // An invalid input date reports day number zero
    a_bad_dn_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == cdo_pkg::ST_W'(cdo_pkg::ST_BAD_DATE) |->
            o_m_tdata[44:23] == 22'd0)
        else $error("invalid date with nonzero day number");

endmodule

bind calendar_date_day_offset_top cdo_checker u_cdo_checker (.*);

`default_nettype wire

// File: tb/calendar_date_day_offset_top_test.sv
// Self-checking testbench for the Gregorian date day-offset block.
`timescale 1ns / 1ps

import cdo_pkg::*;

// Request as packed on the slave tdata: day lowest, zero filler on top
typedef struct packed {
    logic [1:0]              pad;
    logic signed [OFF_W-1:0] offset;
    logic [YEAR_W-1:0]       year;
    logic [MON_W-1:0]        month;
    logic [DAY_W-1:0]        day;
} date_request_t;

// Result as packed on the master tdata
typedef struct packed {
    logic [2:0]        pad;
    logic [DN_W-1:0]   day_number;
    logic [YEAR_W-1:0] year;
    logic [MON_W-1:0]  month;
    logic [DAY_W-1:0]  day;
} date_result_t;

typedef struct packed {
    date_result_t date;
    t_status      status;
} shifted_date_t;

class date_shift_checker;
    int            min_year;
    int            max_year;
    shifted_date_t pending_dates[$];
    int            errors;

    function new();
        min_year = 1900;
        max_year = 9999;
        errors   = 0;
    endfunction

    function bit is_leap(int y);
        return ((y % 4) == 0 && (y % 100) != 0) || ((y % 400) == 0);
    endfunction

    function int month_days(int m, int y);
        int lens[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        if (m < 1 || m > 12) begin
            return 0;
        end
        if (m == 2 && is_leap(y)) begin
            return 29;
        end
        return lens[m-1];
    endfunction

    // Days in all years 0 .. y-1, proleptic Gregorian
    function longint days_to_year(int y);
        longint leaps;
        leaps = (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
        return longint'(y) * 365 + leaps;
    endfunction

    // Day number of a date relative to 1 January of min_year
    function longint date_to_number(int d, int m, int y);
        longint dn;
        int     i;
        dn = days_to_year(y) - days_to_year(min_year);
        for (i = 1; i < m; i++) begin
            dn += month_days(i, y);
        end
        return dn + d - 1;
    endfunction

    function shifted_date_t shift_date(date_request_t req);
        shifted_date_t res;
        longint        base;
        longint        dn;
        longint        total;
        longint        limit;
        longint        rem;
        int            d;
        int            m;
        int            y;
        int            lo;
        int            hi;
        int            mid;
        int            rm;
        d = req.day;
        m = req.month;
        y = req.year;
        res.date            = '0;
        res.date.day        = req.day;
        res.date.month      = req.month;
        res.date.year       = req.year;
        res.status          = ST_BAD_DATE;
        // Reject dates outside the window or with bad month/day
        if (y < min_year || y > max_year || m < 1 || m > 12 ||
            d < 1 || d > month_days(m, y)) begin
            return res;
        end
        base  = days_to_year(min_year);
        dn    = date_to_number(d, m, y);
        total = dn + longint'($signed(req.offset));
        limit = days_to_year(max_year + 1) - base;
        if (total < 0 || total >= limit) begin
            res.date.day_number = DN_W'(dn);
            res.status          = ST_RANGE;
            return res;
        end
        // Find the last year whose 1 January is not past the total
        lo = min_year;
        hi = max_year;
        while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            if (days_to_year(mid) - base <= total) begin
                lo = mid;
            end else begin
                hi = mid - 1;
            end
        end
        rem = total - (days_to_year(lo) - base);
        rm  = 1;
        while (rm < 12 && rem >= month_days(rm, lo)) begin
            rem -= month_days(rm, lo);
            rm++;
        end
        res.date.day        = DAY_W'(rem + 1);
        res.date.month      = MON_W'(rm);
        res.date.year       = YEAR_W'(lo);
        res.date.day_number = DN_W'(total);
        res.status          = ST_OK;
        return res;
    endfunction

    function void report(string msg);
        if (errors < 10) begin
            $display("%s", msg);
        end
        errors++;
    endfunction

    function void note_request(date_request_t req);
        pending_dates.push_back(shift_date(req));
    endfunction

    function void check_result(date_result_t got, t_status st);
        shifted_date_t want;
        if (pending_dates.size() == 0) begin
            report($sformatf("unexpected result d=%0d m=%0d y=%0d dn=%0d st=%0d",
                             got.day, got.month, got.year, got.day_number, st));
            return;
        end
        want = pending_dates.pop_front();
        if (got.day != want.date.day || got.month != want.date.month ||
            got.year != want.date.year || got.day_number != want.date.day_number ||
            st != want.status) begin
            report($sformatf({"mismatch: expected d=%0d m=%0d y=%0d dn=%0d st=%0d, ",
                              "got d=%0d m=%0d y=%0d dn=%0d st=%0d"},
                             want.date.day, want.date.month, want.date.year,
                             want.date.day_number, want.status,
                             got.day, got.month, got.year, got.day_number, st));
        end
    endfunction

    function int pending();
        return pending_dates.size();
    endfunction

    // Count results that never arrived
    function void close();
        if (pending_dates.size() != 0) begin
            report($sformatf("%0d results never arrived", pending_dates.size()));
        end
    endfunction
endclass

module calendar_date_day_offset_top_test;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int N_WINDOWS   = 7;

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr  = CFG_MIN_YEAR;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    // tdata: in_day, in_month, in_year, day_offset, zero
    logic [TDATA_W-1:0]    i_s_tdata   = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    // tdata: out_day, out_month, out_year, day_number, zero
    logic [TDATA_W-1:0]    o_m_tdata;
    // tuser: status
    logic [ST_W-1:0]       o_m_tuser;

    date_shift_checker sb = new();

    int  cycles     = 0;
    int  stall_left = 0;
    bit  tx_gaps    = 1'b0;
    bit  rx_stalls  = 1'b0;

    int  win_lo[N_WINDOWS]    = '{1900, 1, 2000, 9999, 1, 2024, 1583};
    int  win_hi[N_WINDOWS]    = '{9999, 9999, 2100, 9999, 1, 2000, 2400};
    int  win_items[N_WINDOWS] = '{315, 315, 315, 315, 315, 100, 315};

    calendar_date_day_offset_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(0, 2);
        end else if (r < 95) begin
            return $urandom_range(3, 8);
        end
        return $urandom_range(9, 40);
    endfunction

    // Stall the result side at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
            if (rx_stalls && $urandom_range(0, 3) == 0) begin
                stall_left = pick_gap();
            end
        end
    end

    // Predict each accepted request, check each accepted result
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            sb.note_request(date_request_t'(i_s_tdata));
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            sb.check_result(date_result_t'(o_m_tdata), t_status'(o_m_tuser));
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILURE");
            $finish;
        end
    end

    function automatic date_request_t make_request(int d, int m, int y, int off);
        date_request_t r;
        r        = '0;
        r.day    = DAY_W'(d);
        r.month  = MON_W'(m);
        r.year   = YEAR_W'(y);
        r.offset = OFF_W'(off);
        return r;
    endfunction

    function automatic date_request_t random_request(int lo_y, int hi_y);
        date_request_t r;
        int            kind;
        int            sub;
        int            y;
        int            m;
        int            len;
        kind     = $urandom_range(0, 99);
        r        = '0;
        r.offset = OFF_W'($urandom);
        y        = (lo_y <= hi_y) ? $urandom_range(hi_y, lo_y) : $urandom_range(0, 9999);
        m        = $urandom_range(1, 12);
        len      = sb.month_days(m, y);
        r.year   = YEAR_W'(y);
        r.month  = MON_W'(m);
        r.day    = DAY_W'($urandom_range(1, len));
        if (kind < 70) begin
            // Well-formed date, offset mostly near it
            sub = $urandom_range(0, 99);
            if (sub < 35) begin
                r.offset = OFF_W'(int'($urandom_range(0, 800)) - 400);
            end else if (sub < 70) begin
                r.offset = OFF_W'(int'($urandom_range(0, 80000)) - 40000);
            end
        end else if (kind < 85) begin
            // Raw noise over the whole day and month fields, year 0 to 9999
            r.day   = DAY_W'($urandom_range(0, 31));
            r.month = MON_W'($urandom_range(0, 15));
            r.year  = YEAR_W'($urandom_range(0, 9999));
        end else if (kind < 95) begin
            // Broken day or month inside the window, or 29 February
            sub = $urandom_range(0, 3);
            if (sub == 0) begin
                r.day = '0;
            end else if (sub == 1) begin
                r.day = (len < 31) ? DAY_W'($urandom_range(len + 1, 31)) : '0;
            end else if (sub == 2) begin
                r.month = ($urandom_range(0, 1) == 0) ? '0 : MON_W'($urandom_range(13, 15));
                r.day   = DAY_W'($urandom_range(1, 31));
            end else begin
                r.month = MON_W'(2);
                r.day   = DAY_W'(29);
            end
        end else begin
            // Year just outside the window
            if ($urandom_range(0, 1) == 0 && lo_y > 0) begin
                y = lo_y - 1;
            end else if (hi_y < 9999) begin
                y = hi_y + 1;
            end else begin
                y = (lo_y > 0) ? lo_y - 1 : 0;
            end
            r.year = YEAR_W'(y);
            r.day  = DAY_W'($urandom_range(1, 28));
        end
        return r;
    endfunction

    // Present one request and hold it until taken
    task automatic send_date(date_request_t req);
        int gap;
        gap = tx_gaps ? pick_gap() : 0;
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= TDATA_W'(req);
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    // Stop sending and wait for every outstanding result
    task automatic wait_drain();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic set_window(int lo_y, int hi_y);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_MIN_YEAR;
        i_cfg_wdata <= CFG_DATA_W'(lo_y);
        @(posedge i_clk);
        i_cfg_addr  <= CFG_MAX_YEAR;
        i_cfg_wdata <= CFG_DATA_W'(hi_y);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.min_year = lo_y;
        sb.max_year = hi_y;
    endtask

    initial begin
        int last_day;
        int w;
        int n;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed requests under the reset window 1900..9999
        last_day = int'(sb.date_to_number(31, 12, 9999));
        send_date(make_request(1, 1, 1900, 0));
        send_date(make_request(31, 12, 9999, 0));
        send_date(make_request(1, 1, 1900, -1));
        send_date(make_request(31, 12, 9999, 1));
        send_date(make_request(1, 1, 1900, last_day));
        send_date(make_request(1, 1, 1900, 4194303));
        send_date(make_request(31, 12, 9999, -4194304));
        send_date(make_request(31, 12, 9999, -last_day));
        send_date(make_request(29, 2, 2000, 0));
        send_date(make_request(29, 2, 1900, 0));
        send_date(make_request(29, 2, 2004, 365));
        send_date(make_request(29, 2, 2001, 0));
        send_date(make_request(31, 4, 2023, 0));
        send_date(make_request(0, 5, 2023, 0));
        send_date(make_request(1, 0, 2023, 0));
        send_date(make_request(1, 13, 2023, 0));
        send_date(make_request(31, 15, 9999, 0));
        send_date(make_request(31, 1, 2023, 0));
        send_date(make_request(31, 12, 1999, 1));
        send_date(make_request(1, 3, 2000, -1));
        send_date(make_request(28, 2, 2023, 1));
        send_date(make_request(15, 6, 1899, 0));
        send_date(make_request(1, 1, 0, 0));
        send_date(make_request(1, 1, 2100, -1));
        wait_drain();

        // Random requests over a series of year windows
        for (w = 0; w < N_WINDOWS; w++) begin
            if (w != 0) begin
                set_window(win_lo[w], win_hi[w]);
            end
            tx_gaps   = (w % 2) == 1;
            rx_stalls = (w % 3) != 0;
            for (n = 0; n < win_items[w]; n++) begin
                send_date(random_request(win_lo[w], win_hi[w]));
                if ($urandom_range(0, 99) == 0) begin
                    wait_drain();
                end
            end
            wait_drain();
        end

        repeat (40) @(posedge i_clk);
        sb.close();
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
